/* hw/rtl/assert_macros.svh */
// Assertion macros used by the buzzer sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define BZS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define BZS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bzs_pkg.sv */
// Types, codes and constant tables of the buzzer sequencer.
`default_nettype none

package bzs_pkg;

    // Item modes
    typedef enum logic [2:0] {
        MODE_TICK       = 3'd0,
        MODE_START_MEL  = 3'd1,
        MODE_STOP_MEL   = 3'd2,
        MODE_START_BEEP = 3'd3,
        MODE_STOP_BEEP  = 3'd4
    } t_mode;

    // Result actions
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_TONE    = 2'd1,
        ACT_SILENCE = 2'd2
    } t_action;

    // Beep phases
    typedef enum logic [2:0] {
        PH_OFF  = 3'd0,
        PH_WAIT = 3'd1,
        PH_LOW  = 3'd2,
        PH_GAP  = 3'd3,
        PH_HIGH = 3'd4
    } t_beep_phase;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_SCAN,
        ST_M_NOTE,
        ST_M_DUR,
        ST_T_DUR,
        ST_T_NOTE,
        ST_T_NDUR,
        ST_BEEP
    } t_state;

    // Config register indexes
    localparam logic [2:0] CFG_BEEP_WAIT = 3'd0;
    localparam logic [2:0] CFG_BEEP_ON   = 3'd1;
    localparam logic [2:0] CFG_BEEP_GAP  = 3'd2;
    localparam logic [2:0] CFG_BEEP_LOW  = 3'd3;
    localparam logic [2:0] CFG_BEEP_HIGH = 3'd4;

    localparam logic [15:0] BEEP_WAIT_RST = 16'd1500;
    localparam logic [15:0] BEEP_ON_RST   = 16'd50;
    localparam logic [15:0] BEEP_GAP_RST  = 16'd20;
    localparam logic [5:0]  BEEP_LOW_RST  = 6'd13;
    localparam logic [5:0]  BEEP_HIGH_RST = 6'd20;

    // Melody word: bit 16 is the end mark, bits 15:0 note or duration
    localparam int WORD_W   = 17;
    localparam int END_POS  = 16;
    localparam int ROM_LEN  = 35;
    localparam int PITCH_LEN = 61;
    localparam int ROM_ADDR_W = 11;
    localparam logic [WORD_W-1:0] END_WORD = 17'h10000;

    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic start_beep;
        logic stop;
        logic tick;
    } t_beep_cmd;

    typedef struct packed {
        t_action     act;
        logic [11:0] hz;
        logic [15:0] ms;
    } t_tone;

    localparam logic [WORD_W-1:0] MELODY_ROM [ROM_LEN] = '{
        17'd25, 17'd100, 17'd20, 17'd100, 17'd20, 17'd100, END_WORD,
        17'd25, 17'd200, 17'd20, 17'd200, 17'd25, 17'd200, END_WORD,
        17'd25, 17'd100, 17'd30, 17'd100, 17'd40, 17'd100, END_WORD,
        17'd27, 17'd50,  17'd26, 17'd50,  17'd25, 17'd50,  END_WORD,
        17'd25, 17'd50,  17'd26, 17'd50,  17'd27, 17'd50,  END_WORD
    };

    localparam logic [11:0] PITCH_HZ [PITCH_LEN] = '{
        12'd0,
        12'd131,  12'd139,  12'd147,  12'd156,  12'd165,  12'd175,
        12'd185,  12'd196,  12'd208,  12'd220,  12'd233,  12'd247,
        12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
        12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
        12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
        12'd740,  12'd784,  12'd831,  12'd880,  12'd932,  12'd988,
        12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
        12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
        12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
        12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
    };

    // Melody word at an address; past the table it is an end mark
    function automatic logic [WORD_W-1:0] melody_word(logic [ROM_ADDR_W-1:0] addr);
        logic [WORD_W-1:0] w;
        w = END_WORD;
        if (addr < ROM_ADDR_W'(ROM_LEN)) begin
            w = MELODY_ROM[addr[5:0]];
        end
        return w;
    endfunction

    // Note index to hertz; out-of-range notes give 0 Hz
    function automatic logic [11:0] pitch_lookup(logic [15:0] note, int entries);
        logic [11:0] hz;
        hz = 12'd0;
        if ((note < 16'(PITCH_LEN)) && (int'(note) < entries)) begin
            hz = PITCH_HZ[note[5:0]];
        end
        return hz;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bzs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bzs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/bzs_beep.sv */
// Two-tone call beep: config registers, phase and elapsed-time tracking.
`default_nettype none

module bzs_beep #(
    parameter int NOTE_ENTRIES = 61
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bzs_pkg::t_cfg_wr     i_cfg,
    input  wire bzs_pkg::t_beep_cmd   i_cmd,
    output bzs_pkg::t_beep_phase      o_phase,
    output bzs_pkg::t_tone            o_res
);

    logic [15:0] r_wait, r_on, r_gap;
    logic [5:0]  r_low, r_high;
    bzs_pkg::t_beep_phase r_phase, n_phase;
    logic [15:0] r_el, n_el, el_inc;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= bzs_pkg::BEEP_WAIT_RST;
            r_on   <= bzs_pkg::BEEP_ON_RST;
            r_gap  <= bzs_pkg::BEEP_GAP_RST;
            r_low  <= bzs_pkg::BEEP_LOW_RST;
            r_high <= bzs_pkg::BEEP_HIGH_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bzs_pkg::CFG_BEEP_WAIT: r_wait <= i_cfg.data;
                bzs_pkg::CFG_BEEP_ON:   r_on   <= i_cfg.data;
                bzs_pkg::CFG_BEEP_GAP:  r_gap  <= i_cfg.data;
                bzs_pkg::CFG_BEEP_LOW:  r_low  <= i_cfg.data[5:0];
                bzs_pkg::CFG_BEEP_HIGH: r_high <= i_cfg.data[5:0];
                default: ;
            endcase
        end
    end

    // Saturating millisecond count
    assign el_inc = (r_el == 16'hFFFF) ? r_el : r_el + 16'd1;

    // Phase update and the tone it asks for
    always_comb begin
        n_phase = r_phase;
        n_el    = r_el;
        o_res   = '0;
        priority if (i_cmd.start_beep) begin
            n_phase = bzs_pkg::PH_WAIT;
            n_el    = '0;
        end else if (i_cmd.stop) begin
            n_phase = bzs_pkg::PH_OFF;
        end else if (i_cmd.tick && (r_phase != bzs_pkg::PH_OFF)) begin
            n_el = el_inc;
            case (r_phase)
                bzs_pkg::PH_WAIT: begin
                    if (el_inc > r_wait) begin
                        n_phase  = bzs_pkg::PH_LOW;
                        n_el     = '0;
                        o_res.act = bzs_pkg::ACT_TONE;
                        o_res.hz  = bzs_pkg::pitch_lookup(16'(r_low), NOTE_ENTRIES);
                        o_res.ms  = r_wait;
                    end
                end
                bzs_pkg::PH_LOW: begin
                    if (el_inc > r_on) begin
                        n_phase   = bzs_pkg::PH_GAP;
                        n_el      = '0;
                        o_res.act = bzs_pkg::ACT_SILENCE;
                    end
                end
                bzs_pkg::PH_GAP: begin
                    if (el_inc > r_gap) begin
                        n_phase  = bzs_pkg::PH_HIGH;
                        n_el     = '0;
                        o_res.act = bzs_pkg::ACT_TONE;
                        o_res.hz  = bzs_pkg::pitch_lookup(16'(r_high), NOTE_ENTRIES);
                        o_res.ms  = r_wait;
                    end
                end
                bzs_pkg::PH_HIGH: begin
                    if (el_inc > r_on) begin
                        n_phase   = bzs_pkg::PH_WAIT;
                        n_el      = '0;
                        o_res.act = bzs_pkg::ACT_SILENCE;
                    end
                end
                default: ;
            endcase
        end else begin
            // No command: phase and count hold
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bzs_pkg::PH_OFF;
            r_el    <= '0;
        end else begin
            r_phase <= n_phase;
            r_el    <= n_el;
        end
    end

    assign o_phase = r_phase;

endmodule

`default_nettype wire

/* hw/rtl/buzzer_melody_and_beep_sequencer_unit.sv */
// Top level of the buzzer melody and beep sequencer.
// Usage:
//  - Items enter on start/busy: an item is taken at a clock edge with start
//    high and busy low. i_mode selects tick (1 ms), start melody, stop
//    melody, start beep or stop beep.
//  - Every item gives exactly one result on o_action, o_tone_hz, o_tone_ms,
//    o_melody_on and o_beep_phase, shown for one cycle with o_result_strobe.
//    The receiver cannot hold results off; busy is low again in the strobe
//    cycle, so the next item may be taken then.
//  - Stop/beep commands give their result from the result registers; a tick
//    makes up to three dependent reads of the melody RAM; start melody scans
//    one melody word per cycle through the RAM read port.
//  - Config writes (i_cfg_valid, always ready) are taken at any time, but
//    are meant to land while no item is in flight.
//  - After reset the melody RAM is loaded from the constant table, one word
//    a cycle, with busy high while it fills. The sequencer resets to its fill
//    state and the beep phase to off; config registers reset to defaults.
`default_nettype none

module buzzer_melody_and_beep_sequencer_unit #(
    parameter int MELODY_WORDS = 64,
    parameter int NOTE_ENTRIES = 61
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [3:0]  i_melody_number,
    input  wire logic        i_beep_after,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_result_strobe,
    output logic [1:0]       o_action,
    output logic [11:0]      o_tone_hz,
    output logic [15:0]      o_tone_ms,
    output logic             o_melody_on,
    output logic [2:0]       o_beep_phase
);

`include "assert_macros.svh"

    localparam int AW  = $clog2(MELODY_WORDS);
    localparam int RAW = AW + 1;
    localparam int SCAN_LIM = (MELODY_WORDS < bzs_pkg::ROM_LEN) ?
                              MELODY_WORDS : bzs_pkg::ROM_LEN;
    localparam int WW = bzs_pkg::WORD_W;

    bzs_pkg::t_state  r_state, n_state;
    logic             r_mel_act, n_mel_act;
    logic [RAW-1:0]   r_start, n_start;
    logic [RAW-1:0]   r_step, n_step;
    logic [15:0]      r_note_el, n_note_el;
    logic             r_after_end, n_after_end;
    logic [3:0]       r_num, n_num;
    logic             r_after, n_after;
    logic [RAW-1:0]   r_idx, n_idx;
    logic [4:0]       r_cnt, n_cnt;
    logic [15:0]      r_word, n_word;
    logic             r_oob;
    logic [AW-1:0]    r_fill;
    logic             r_out_vld, n_out_vld;
    bzs_pkg::t_action r_act, n_act;
    logic [11:0]      r_hz, n_hz;
    logic [15:0]      r_ms, n_ms;

    logic [RAW-1:0]   rd_addr;
    logic             rd_oob;
    logic [WW-1:0]    ram_q;
    logic [WW-1:0]    word;
    logic [4:0]       cnt_eff;
    logic             scan_found;
    logic [15:0]      el_inc;
    logic             el_over;
    bzs_pkg::t_tone   note_res;
    bzs_pkg::t_tone   beep_res;
    bzs_pkg::t_beep_cmd   beep_cmd;
    bzs_pkg::t_beep_phase beep_phase;
    bzs_pkg::t_cfg_wr     cfg_wr;

    // Tone or silence for a melody note
    function automatic bzs_pkg::t_tone emit_note(logic [15:0] note, logic [15:0] dur);
        bzs_pkg::t_tone res;
        res = '0;
        if (note != 16'd0) begin
            res.act = bzs_pkg::ACT_TONE;
            res.hz  = bzs_pkg::pitch_lookup(note, NOTE_ENTRIES);
            res.ms  = dur;
        end else begin
            res.act = bzs_pkg::ACT_SILENCE;
        end
        return res;
    endfunction

    // Melody word store, loaded after reset
    bzs_ram #(
        .WIDTH (WW),
        .DEPTH (MELODY_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == bzs_pkg::ST_FILL),
        .i_waddr (r_fill),
        .i_wdata (bzs_pkg::melody_word(bzs_pkg::ROM_ADDR_W'(r_fill))),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (ram_q)
    );

    // Call beep
    assign cfg_wr = '{valid: i_cfg_valid, index: i_cfg_index, data: i_cfg_data};

    bzs_beep #(
        .NOTE_ENTRIES (NOTE_ENTRIES)
    ) u_beep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_wr),
        .i_cmd   (beep_cmd),
        .o_phase (beep_phase),
        .o_res   (beep_res)
    );

    // Read data; addresses past the store read as an end mark
    assign word    = r_oob ? bzs_pkg::END_WORD : ram_q;
    assign rd_oob  = (rd_addr >= RAW'(MELODY_WORDS));
    assign cnt_eff = r_cnt + 5'((r_idx != '0) && word[bzs_pkg::END_POS]);
    assign scan_found = (cnt_eff == {1'b0, r_num});
    assign el_inc  = (r_note_el == 16'hFFFF) ? r_note_el : r_note_el + 16'd1;
    assign el_over = (el_inc > word[15:0]);
    assign note_res = emit_note(r_word, word[15:0]);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bzs_pkg::ST_FILL: begin
                if (r_fill == AW'(MELODY_WORDS - 1)) n_state = bzs_pkg::ST_IDLE;
            end
            bzs_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_mode == bzs_pkg::MODE_TICK) begin
                        n_state = r_mel_act ? bzs_pkg::ST_T_DUR : bzs_pkg::ST_BEEP;
                    end else if (i_mode == bzs_pkg::MODE_START_MEL) begin
                        n_state = bzs_pkg::ST_SCAN;
                    end
                end
            end
            bzs_pkg::ST_SCAN: begin
                if (scan_found) begin
                    n_state = bzs_pkg::ST_M_NOTE;
                end else if (r_idx == RAW'(SCAN_LIM - 1)) begin
                    n_state = bzs_pkg::ST_IDLE;
                end
            end
            bzs_pkg::ST_M_NOTE: n_state = bzs_pkg::ST_M_DUR;
            bzs_pkg::ST_M_DUR:  n_state = bzs_pkg::ST_IDLE;
            bzs_pkg::ST_T_DUR:  n_state = el_over ? bzs_pkg::ST_T_NOTE : bzs_pkg::ST_BEEP;
            bzs_pkg::ST_T_NOTE: begin
                n_state = word[bzs_pkg::END_POS] ? bzs_pkg::ST_BEEP : bzs_pkg::ST_T_NDUR;
            end
            bzs_pkg::ST_T_NDUR: n_state = bzs_pkg::ST_BEEP;
            bzs_pkg::ST_BEEP:   n_state = bzs_pkg::ST_IDLE;
            default:            n_state = bzs_pkg::ST_IDLE;
        endcase
    end

    // Datapath, RAM reads and results
    always_comb begin
        n_mel_act   = r_mel_act;
        n_start     = r_start;
        n_step      = r_step;
        n_note_el   = r_note_el;
        n_after_end = r_after_end;
        n_num       = r_num;
        n_after     = r_after;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_word      = r_word;
        n_out_vld   = 1'b0;
        n_act       = r_act;
        n_hz        = r_hz;
        n_ms        = r_ms;
        rd_addr     = '0;
        beep_cmd    = '0;
        unique case (r_state)
            bzs_pkg::ST_IDLE: begin
                if (start) begin
                    n_num   = i_melody_number;
                    n_after = i_beep_after;
                    n_act   = bzs_pkg::ACT_NONE;
                    n_hz    = '0;
                    n_ms    = '0;
                    case (bzs_pkg::t_mode'(i_mode))
                        bzs_pkg::MODE_TICK: begin
                            rd_addr = r_start + r_step + RAW'(1);
                        end
                        bzs_pkg::MODE_START_MEL: begin
                            n_idx = '0;
                            n_cnt = '0;
                        end
                        bzs_pkg::MODE_STOP_MEL: begin
                            n_act     = bzs_pkg::ACT_SILENCE;
                            n_mel_act = 1'b0;
                            n_start   = '0;
                            n_step    = '0;
                            beep_cmd.start_beep = i_beep_after;
                            n_out_vld = 1'b1;
                        end
                        bzs_pkg::MODE_START_BEEP: begin
                            beep_cmd.start_beep = 1'b1;
                            n_out_vld = 1'b1;
                        end
                        bzs_pkg::MODE_STOP_BEEP: begin
                            beep_cmd.stop = 1'b1;
                            n_act     = bzs_pkg::ACT_SILENCE;
                            n_out_vld = 1'b1;
                        end
                        default: n_out_vld = 1'b1;
                    endcase
                end
            end
            // Count end marks one word a cycle until melody r_num begins
            bzs_pkg::ST_SCAN: begin
                if (scan_found) begin
                    n_start = r_idx;
                    rd_addr = r_idx;
                end else if (r_idx == RAW'(SCAN_LIM - 1)) begin
                    n_out_vld = 1'b1;
                end else begin
                    n_cnt   = cnt_eff;
                    n_idx   = r_idx + RAW'(1);
                    rd_addr = r_idx;
                end
            end
            bzs_pkg::ST_M_NOTE: begin
                n_word  = word[15:0];
                rd_addr = r_start + RAW'(1);
            end
            bzs_pkg::ST_M_DUR: begin
                beep_cmd.stop = 1'b1;
                n_step      = '0;
                n_note_el   = '0;
                n_mel_act   = 1'b1;
                n_after_end = r_after;
                n_act       = note_res.act;
                n_hz        = note_res.hz;
                n_ms        = note_res.ms;
                n_out_vld   = 1'b1;
            end
            // Current note duration is in; advance when it has run out
            bzs_pkg::ST_T_DUR: begin
                n_note_el = el_inc;
                if (el_over) begin
                    n_step  = r_step + RAW'(2);
                    rd_addr = r_start + r_step + RAW'(2);
                end
            end
            bzs_pkg::ST_T_NOTE: begin
                if (word[bzs_pkg::END_POS]) begin
                    n_act     = bzs_pkg::ACT_SILENCE;
                    n_mel_act = 1'b0;
                    n_start   = '0;
                    n_step    = '0;
                    beep_cmd.start_beep = r_after_end;
                end else begin
                    n_note_el = '0;
                    n_word    = word[15:0];
                    rd_addr   = r_start + r_step + RAW'(1);
                end
            end
            bzs_pkg::ST_T_NDUR: begin
                n_act = note_res.act;
                n_hz  = note_res.hz;
                n_ms  = note_res.ms;
            end
            // Beep advances too; melody action wins
            bzs_pkg::ST_BEEP: begin
                beep_cmd.tick = 1'b1;
                if (r_act == bzs_pkg::ACT_NONE) begin
                    n_act = beep_res.act;
                    n_hz  = beep_res.hz;
                    n_ms  = beep_res.ms;
                end
                n_out_vld = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bzs_pkg::ST_FILL;
            r_fill      <= '0;
            r_mel_act   <= 1'b0;
            r_start     <= '0;
            r_step      <= '0;
            r_note_el   <= '0;
            r_after_end <= 1'b0;
            r_num       <= '0;
            r_after     <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_oob       <= 1'b0;
            r_out_vld   <= 1'b0;
            r_act       <= bzs_pkg::ACT_NONE;
            r_hz        <= '0;
            r_ms        <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= r_fill + AW'(1);
            r_mel_act   <= n_mel_act;
            r_start     <= n_start;
            r_step      <= n_step;
            r_note_el   <= n_note_el;
            r_after_end <= n_after_end;
            r_num       <= n_num;
            r_after     <= n_after;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_oob       <= rd_oob;
            r_out_vld   <= n_out_vld;
            r_act       <= n_act;
            r_hz        <= n_hz;
            r_ms        <= n_ms;
        end
    end

    // Note latch needs no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign busy            = (r_state != bzs_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_result_strobe = r_out_vld;
    assign o_action        = r_act;
    assign o_tone_hz       = r_hz;
    assign o_tone_ms       = r_ms;
    assign o_melody_on     = r_mel_act;
    assign o_beep_phase    = beep_phase;

    // Checks
    `BZS_ASSERT_IMP(a_tone_fields, i_clk, i_rst_n, o_result_strobe && (r_act != bzs_pkg::ACT_TONE), (r_hz == 12'd0) && (r_ms == 16'd0), "tone fields set without a tone")
    `BZS_ASSERT_IMP(a_step_idle, i_clk, i_rst_n, !r_mel_act, r_step == '0, "melody step nonzero while no melody plays")
    `BZS_ASSERT_NXT(a_walk_busy, i_clk, i_rst_n, start && !busy && ((i_mode == bzs_pkg::MODE_TICK) || (i_mode == bzs_pkg::MODE_START_MEL)), busy, "tick or melody start did not occupy the sequencer")

endmodule

`default_nettype wire
